/* design/uri_percent_escape_normalizer_assert.svh */
// Assertion macros shared by the URI percent-escape normalizer RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef URI_PERCENT_ESCAPE_NORMALIZER_ASSERT_SVH
`define URI_PERCENT_ESCAPE_NORMALIZER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define UPEN_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upen assertion failed");

// Next-cycle implication, held off during reset
`define UPEN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upen assertion failed");

`endif

/* design/upen_pkg.sv */
// Shared types, constants and character-class functions for the
// URI percent-escape normalizer. No dependencies.
`default_nettype none

package upen_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_RAW_BAD    = 3'd1,
    ST_DISALLOWED = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_BAD_HEX    = 3'd4,
    ST_ENC_BAD    = 3'd5
  } status_t;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_t    status;
  } result_t;

  localparam int GROUP_MAX  = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int GCNT_W     = $clog2(GROUP_MAX + 1);

  // Results made by one input byte: 0, 1 or 3 of them, in order
  typedef struct packed {
    logic [GCNT_W-1:0]             count;
    result_t [GROUP_MAX-1:0]       res;
  } group_t;

  // Character constants
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7f;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_QMARK   = 8'h3f;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h00;

  function automatic logic is_unreserved(logic [7:0] c);
    logic r;
    r = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
        (c >= 8'h30 && c <= 8'h39) || c == 8'h2d || c == 8'h2e ||
        c == 8'h5f || c == 8'h7e;
    return r;
  endfunction

  function automatic logic is_sub_delim(logic [7:0] c);
    logic r;
    r = c == 8'h21 || c == 8'h24 || c == 8'h26 || c == 8'h27 ||
        c == 8'h28 || c == 8'h29 || c == 8'h2a || c == 8'h2b ||
        c == 8'h2c || c == 8'h3b || c == 8'h3d;
    return r;
  endfunction

  // Raw byte allowed in a path segment (mode 0) or query (mode 1)
  function automatic logic raw_allowed(logic [7:0] c, logic qmode);
    logic r;
    r = is_unreserved(c) || is_sub_delim(c) || c == 8'h3a || c == 8'h40 ||
        (qmode && (c == CH_SLASH || c == CH_QMARK));
    return r;
  endfunction

  // Hex digit value in [3:0]; bit 4 set when not a hex digit
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

  // Upper-case hex character for a nibble
  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/upen_core.sv */
// Input register, escape/validation state and the per-byte step logic.
// Uses upen_pkg and the assertion macros header.
`default_nettype none

`include "uri_percent_escape_normalizer_assert.svh"

module upen_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire logic              query_mode,
  input  wire logic              space_ok,
  output upen_pkg::group_t       grp
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // Input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;

  // Escape and discard state
  phase_t     phase, phase_next;
  logic [3:0] held, held_next;
  logic       discarding, discarding_next;

  logic       fire;
  logic       take;
  logic [4:0] nib;
  logic [7:0] dec;

  // Step only when the result queue has room for a full group
  assign fire     = hold_valid && space_ok;
  assign in_stall = hold_valid && !space_ok;
  assign take     = in_valid && !in_stall;

  // Per-byte step
  always_comb begin
    phase_next      = phase;
    held_next       = held;
    discarding_next = discarding;
    grp             = '0;
    nib             = upen_pkg::hex_nibble(hold_byte);
    dec             = {held, nib[3:0]};

    if (fire) begin
      if (discarding) begin
        // drop bytes up to the end of the string
        if (hold_last) begin
          discarding_next = 1'b0;
          phase_next      = PH_IDLE;
          held_next       = 4'h0;
        end
      end else begin
        case (phase)
          PH_HIGH: begin
            if (hold_last) begin
              grp.count         = upen_pkg::GCNT_W'(1);
              grp.res[0].status = upen_pkg::ST_INCOMPLETE;
            end else if (nib[4]) begin
              grp.count         = upen_pkg::GCNT_W'(1);
              grp.res[0].status = upen_pkg::ST_BAD_HEX;
            end else begin
              held_next  = nib[3:0];
              phase_next = PH_LOW;
            end
          end
          PH_LOW: begin
            if (nib[4]) begin
              grp.count         = upen_pkg::GCNT_W'(1);
              grp.res[0].status = upen_pkg::ST_BAD_HEX;
            end else if (dec < upen_pkg::CH_SPACE || dec == upen_pkg::CH_DEL ||
                         dec == upen_pkg::CH_BSLASH ||
                         (!query_mode && dec == upen_pkg::CH_SLASH)) begin
              grp.count         = upen_pkg::GCNT_W'(1);
              grp.res[0].status = upen_pkg::ST_ENC_BAD;
            end else if (upen_pkg::is_unreserved(dec)) begin
              // decode in place
              grp.count       = upen_pkg::GCNT_W'(1);
              grp.res[0].data = dec;
              grp.res[0].last = hold_last;
              phase_next      = PH_IDLE;
              held_next       = 4'h0;
            end else begin
              // re-emit with upper-case hex
              grp.count       = upen_pkg::GCNT_W'(3);
              grp.res[0].data = upen_pkg::CH_PERCENT;
              grp.res[1].data = upen_pkg::hex_char(held);
              grp.res[2].data = upen_pkg::hex_char(nib[3:0]);
              grp.res[2].last = hold_last;
              phase_next      = PH_IDLE;
              held_next       = 4'h0;
            end
          end
          default: begin
            if (hold_byte <= upen_pkg::CH_SPACE || hold_byte == upen_pkg::CH_DEL ||
                hold_byte == upen_pkg::CH_BSLASH || hold_byte[7]) begin
              grp.count         = upen_pkg::GCNT_W'(1);
              grp.res[0].status = upen_pkg::ST_RAW_BAD;
            end else if (hold_byte == upen_pkg::CH_PERCENT) begin
              if (hold_last) begin
                grp.count         = upen_pkg::GCNT_W'(1);
                grp.res[0].status = upen_pkg::ST_INCOMPLETE;
              end else begin
                phase_next = PH_HIGH;
              end
            end else if (!upen_pkg::raw_allowed(hold_byte, query_mode)) begin
              grp.count         = upen_pkg::GCNT_W'(1);
              grp.res[0].status = upen_pkg::ST_DISALLOWED;
            end else begin
              grp.count       = upen_pkg::GCNT_W'(1);
              grp.res[0].data = hold_byte;
              grp.res[0].last = hold_last;
            end
          end
        endcase

        // any error ends the string and starts discarding unless last
        if (grp.count != '0 && grp.res[0].status != upen_pkg::ST_OK) begin
          grp.res[0].data = upen_pkg::CH_ZERO;
          grp.res[0].last = 1'b1;
          phase_next      = PH_IDLE;
          held_next       = 4'h0;
          discarding_next = !hold_last;
        end
      end
    end
  end

  // State and input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= PH_IDLE;
      held       <= 4'h0;
      discarding <= 1'b0;
    end else begin
      phase      <= phase_next;
      held       <= held_next;
      discarding <= discarding_next;
      if (take) begin
        hold_valid <= 1'b1;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
    end
    if (take) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

  // Checks
  `UPEN_ASSERT_NOW(a_no_escape_while_discarding, clk, rst,
    phase != PH_IDLE, !discarding)
  `UPEN_ASSERT_NOW(a_group_size, clk, rst,
    1'b1, grp.count != upen_pkg::GCNT_W'(2))
  `UPEN_ASSERT_NOW(a_error_result_form, clk, rst,
    grp.count != '0 && grp.res[0].status != upen_pkg::ST_OK,
    grp.count == upen_pkg::GCNT_W'(1) && grp.res[0].last && grp.res[0].data == '0)

endmodule

`default_nettype wire

/* design/upen_fifo.sv */
// Result queue: takes a group of up to three results per cycle and
// delivers one result beat per cycle unless stalled. Uses upen_pkg and the assertion macros.
`default_nettype none

`include "uri_percent_escape_normalizer_assert.svh"

module upen_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire upen_pkg::group_t  grp,
  output logic                   space_ok,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output upen_pkg::result_t      head
);

  upen_pkg::result_t                 mem [upen_pkg::FIFO_DEPTH];
  logic [upen_pkg::PTR_W-1:0]        wr_ptr;
  logic [upen_pkg::PTR_W-1:0]        rd_ptr;
  logic [upen_pkg::CNT_W-1:0]        count;
  logic [upen_pkg::CNT_W-1:0]        count_next;
  logic                              pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];
  assign space_ok  = count <= upen_pkg::CNT_W'(upen_pkg::FIFO_DEPTH - upen_pkg::GROUP_MAX);

  assign count_next = count + upen_pkg::CNT_W'(grp.count) - upen_pkg::CNT_W'(pop);

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + upen_pkg::PTR_W'(grp.count);
      rd_ptr <= rd_ptr + upen_pkg::PTR_W'(pop);
      count  <= count_next;
    end
  end

  // Group write, one entry per result in order
  always_ff @(posedge clk) begin
    for (int i = 0; i < upen_pkg::GROUP_MAX; i++) begin
      if (upen_pkg::GCNT_W'(i) < grp.count) begin
        mem[wr_ptr + upen_pkg::PTR_W'(i)] <= grp.res[i];
      end
    end
  end

  // Checks
  `UPEN_ASSERT_NOW(a_count_bound, clk, rst,
    1'b1, count <= upen_pkg::CNT_W'(upen_pkg::FIFO_DEPTH))
  `UPEN_ASSERT_NOW(a_push_has_room, clk, rst,
    grp.count != '0, space_ok)
  `UPEN_ASSERT_NEXT(a_idle_count_holds, clk, rst,
    grp.count == '0 && !pop, $stable(count))

endmodule

`default_nettype wire

/* design/uri_percent_escape_normalizer.sv */
// An input beat passes the input register, then the result queue, before its
// first result beat; three-byte re-emissions follow on consecutive cycles unless
// out_stall holds them. Throughput: one input beat per cycle while the queue has
// room for a full group, one result beat per cycle while out_stall is low, set by
// the single read port of the 8-entry result queue. Reset (rst, synchronous):
// escape/discard state cleared, queue emptied, query_mode back to path mode.
`default_nettype none

module uri_percent_escape_normalizer (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  // input bytes
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  // results
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [2:0]      status
);

  logic                query_mode;
  logic                space_ok;
  upen_pkg::group_t    grp;
  upen_pkg::result_t   head;

  // Mode register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      query_mode <= cfg_data;
    end
  end

  upen_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .query_mode (query_mode),
    .space_ok   (space_ok),
    .grp        (grp)
  );

  upen_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte = head.data;
  assign out_last = head.last;
  assign status   = head.status;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the URI percent-escape normalizer: random and directed
// path/query strings are checked against a cycle-free model of the normalizer.
// Depends on upen_pkg and uri_percent_escape_normalizer.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 5;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_TICKS = 12;
  localparam int PHASE_BYTES  = 120;
  localparam int IDLE_PCT     = 6;
  localparam int HOLD_TICKS   = 100;

  // where the normalizer is inside a percent escape
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HIGH = 2'd2
  } esc_state_t;

  typedef enum logic {
    MODE_PATH  = 1'b0,
    MODE_QUERY = 1'b1
  } comp_mode_t;

  // one input beat of component text
  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } text_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic [2:0] status;

  uri_percent_escape_normalizer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .status    (status)
  );

  always #HALF_PERIOD clk = ~clk;

  text_beat_t          pending_text[$];
  upen_pkg::result_t   expected_beats[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  int         bytes_queued = 0;
  logic       in_fire = 1'b0;
  bit         calm = 1'b0;
  bit         hold_go = 1'b0;
  logic       hold_on = 1'b0;

  // normalizer model state
  comp_mode_t mode_sel;
  esc_state_t esc_state;
  logic [3:0] high_nib;
  logic       dropping;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Normalizer model
  // ---------------------------------------------------------------------
  function automatic bit unreserved_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == "-" || c == "." || c == "_" || c == "~";
  endfunction

  function automatic bit raw_ok(logic [7:0] c, comp_mode_t m);
    bit delim;
    delim = c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
            c == "*" || c == "+" || c == "," || c == ";" || c == "=";
    return unreserved_char(c) || delim || c == ":" || c == "@" ||
           (m == MODE_QUERY && (c == upen_pkg::CH_SLASH || c == upen_pkg::CH_QMARK));
  endfunction

  // bit 4 set when c is not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return 5'(c[3:0] + 4'd9);
    return 5'h10;
  endfunction

  function automatic logic [7:0] upper_hex(logic [3:0] n);
    return (n < 4'd10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n - 4'd10);
  endfunction

  function automatic void push_result(logic [7:0] b, logic l, upen_pkg::status_t st);
    upen_pkg::result_t r;
    r.data   = b;
    r.last   = l;
    r.status = st;
    expected_beats = {expected_beats, r};
  endfunction

  function automatic void clear_escape();
    esc_state = ESC_NONE;
    high_nib  = 4'h0;
  endfunction

  // one status beat, then drop up to the end of the string
  function automatic void flag_error(upen_pkg::status_t st, logic l);
    push_result(8'h00, 1'b1, st);
    clear_escape();
    dropping = !l;
  endfunction

  function automatic void normalize_beat(logic [7:0] c, logic l);
    logic [4:0] nib;
    logic [7:0] dec;
    nib = hex_value(c);
    dec = {high_nib, nib[3:0]};
    if (dropping) begin
      if (l) begin
        dropping = 1'b0;
        clear_escape();
      end
      return;
    end
    case (esc_state)
      ESC_PCT: begin
        if (l) flag_error(upen_pkg::ST_INCOMPLETE, l);
        else if (nib[4]) flag_error(upen_pkg::ST_BAD_HEX, l);
        else begin
          high_nib  = nib[3:0];
          esc_state = ESC_HIGH;
        end
      end
      ESC_HIGH: begin
        if (nib[4]) flag_error(upen_pkg::ST_BAD_HEX, l);
        else if (dec < upen_pkg::CH_SPACE || dec == upen_pkg::CH_DEL ||
                 dec == upen_pkg::CH_BSLASH ||
                 (mode_sel == MODE_PATH && dec == upen_pkg::CH_SLASH))
          flag_error(upen_pkg::ST_ENC_BAD, l);
        else if (unreserved_char(dec)) begin
          push_result(dec, l, upen_pkg::ST_OK);
          clear_escape();
        end else begin
          push_result(upen_pkg::CH_PERCENT, 1'b0, upen_pkg::ST_OK);
          push_result(upper_hex(dec[7:4]), 1'b0, upen_pkg::ST_OK);
          push_result(upper_hex(dec[3:0]), l, upen_pkg::ST_OK);
          clear_escape();
        end
      end
      default: begin
        if (c <= upen_pkg::CH_SPACE || c == upen_pkg::CH_DEL ||
            c == upen_pkg::CH_BSLASH || c[7])
          flag_error(upen_pkg::ST_RAW_BAD, l);
        else if (c == upen_pkg::CH_PERCENT) begin
          if (l) flag_error(upen_pkg::ST_INCOMPLETE, l);
          else esc_state = ESC_PCT;
        end else if (!raw_ok(c, mode_sel)) flag_error(upen_pkg::ST_DISALLOWED, l);
        else push_result(c, l, upen_pkg::ST_OK);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: predict on accepted input beats, check accepted result beats
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    upen_pkg::result_t want;
    if (rst) begin
      mode_sel  = MODE_PATH;
      dropping  = 1'b0;
      clear_escape();
    end else begin
      if (cfg_valid && cfg_ready) mode_sel = comp_mode_t'(cfg_data);
      if (in_valid && !in_stall) normalize_beat(in_byte, in_last);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat byte=%0h last=%0b status=%0d",
                                    out_byte, out_last, status));
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %0h, want %0h", out_byte, want.data));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        end
      end
    end
    in_fire <= !rst && in_valid && !in_stall;
  end

  // ---------------------------------------------------------------------
  // Input driver: new beat only once the previous one was taken
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : text_driver
    text_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_text.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_text.pop_front();
        in_valid <= 1'b1;
        in_byte  <= nxt.b;
        in_last  <= nxt.l;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin : sink_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || (!calm && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Long receiver hold-off so the result queue fills and the input stalls
  initial begin : long_hold
    wait (hold_go);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_TICKS) @(negedge clk);
    hold_on <= 1'b0;
  end

  // Run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic l);
    text_beat_t t;
    t.b = b;
    t.l = l;
    pending_text = {pending_text, t};
    bytes_queued++;
  endtask

  // whole string, last flag on its final byte
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] plain_char();
    string pool;
    int    pick;
    pool = "-._~!$&'()*+,;=:@/?";
    pick = $urandom_range(0, 99);
    if (pick < 30) return 8'("a") + 8'($urandom_range(0, 25));
    if (pick < 50) return 8'("A") + 8'($urandom_range(0, 25));
    if (pick < 65) return 8'("0") + 8'($urandom_range(0, 9));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] digit_char();
    string pool;
    pool = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 99) < 6) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // mostly well-formed text and escapes, some noise; cutting to length may
  // leave an escape unfinished at the end of the string
  task automatic push_random_string();
    logic [7:0] body[$];
    int         len;
    int         pick;
    len = $urandom_range(1, 10);
    while (body.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        body = {body, plain_char()};
      end else if (pick < 88) begin
        body = {body, upen_pkg::CH_PERCENT};
        body = {body, digit_char()};
        body = {body, digit_char()};
      end else begin
        body = {body, 8'($urandom_range(0, 255))};
      end
    end
    if (body.size() > len) body = body[0:len-1];
    foreach (body[i]) push_byte(body[i], i == len - 1);
  endtask

  // everything sent and answered, then let in-flight work settle
  task automatic drain();
    while (pending_text.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_mode(input comp_mode_t m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase();
    int start;
    start = bytes_queued;
    while (bytes_queued - start < PHASE_BYTES) push_random_string();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed cases, path mode
    write_mode(MODE_PATH);
    push_text("%7e");            // lower-case hex, decodes to unreserved
    push_text("%2f");            // encoded slash in a path, error on last byte
    push_text("%G");             // non-hex high digit on the last byte
    push_text("%Gx");            // bad high digit, then dropped tail
    push_text("%4z");            // bad low digit
    push_text("%20");            // decoded space goes back out escaped
    push_byte(8'hff, 1'b1);      // non-ASCII raw byte
    push_byte(8'h00, 1'b1);      // control raw byte
    push_text("%");              // percent cut off by the end of string
    push_text("/b");             // slash not allowed raw in a path
    push_byte("a", 1'b0);        // string left open across the mode change
    drain();

    // query mode picks up mid-string
    write_mode(MODE_QUERY);
    push_byte(upen_pkg::CH_SLASH, 1'b1);
    push_text("%2F");
    drain();

    // random phases; the first one carries the long hold-off
    random_phase();
    hold_go = 1'b1;
    drain();

    write_mode(MODE_PATH);
    calm = 1'b1;
    random_phase();
    drain();
    calm = 1'b0;

    write_mode(MODE_QUERY);
    random_phase();
    drain();

    write_mode(MODE_PATH);
    random_phase();
    drain();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* uri_percent_escape_normalizer.f */
+incdir+design
design/upen_pkg.sv
design/upen_core.sv
design/upen_fifo.sv
design/uri_percent_escape_normalizer.sv
bench/tb_top.sv
